### rtl/dahr_pkg.sv
// Shared types, constants and charge ROM for the dual-anode hit reconstruction core.
`default_nettype none
package dahr_pkg;

   localparam int ChannelWidth  = 32;
   localparam int EnergyWidth   = 24;
   localparam int TimeWidth     = 13;
   localparam int AdcWidth      = 8;
   localparam int TdcWidth      = 6;
   localparam int PedWidth      = 10;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 10;
   localparam int EdgeWidth     = 22;

   localparam logic signed [TimeWidth-1:0] TIME_INVALID = -13'sd4000;

   localparam logic [PedWidth-1:0] PEDESTAL_RESET = 10'd90;
   localparam logic [TdcWidth-1:0] EARLY_CUT_RESET = 6'd20;
   localparam logic [TdcWidth-1:0] TDC_MAX_RESET = 6'd49;

   typedef enum logic [1:0] {
      FUNC_ANODE1    = 2'd0,
      FUNC_ANODE2    = 2'd1,
      FUNC_BOTH_CUT  = 2'd2,
      FUNC_BOTH_FREE = 2'd3
   } func_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_PEDESTAL  = 2'd0,
      CSR_EARLY_CUT = 2'd1,
      CSR_TDC_MAX   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [PedWidth-1:0] pedestal_tenth_fc;
      logic [TdcWidth-1:0] early_time_cut;
      logic [TdcWidth-1:0] tdc_valid_max;
   } cfg_type;

   // ROM bin edges in 0.1 fC; bin k spans edge k to edge k+1
   localparam logic [EdgeWidth-1:0] BIN_EDGE [257] = '{
      22'd0, 22'd32, 22'd64, 22'd96, 22'd128, 22'd160, 22'd192, 22'd224,
      22'd256, 22'd288, 22'd320, 22'd352, 22'd384, 22'd416, 22'd448, 22'd480,
      22'd544, 22'd608, 22'd672, 22'd736, 22'd800, 22'd864,
      22'd928, 22'd992, 22'd1056, 22'd1120, 22'd1184, 22'd1248, 22'd1312,
      22'd1376, 22'd1440, 22'd1504, 22'd1568, 22'd1632,
      22'd1696, 22'd1760, 22'd1888, 22'd2016, 22'd2144, 22'd2272, 22'd2400,
      22'd2528, 22'd2656, 22'd2784, 22'd2912, 22'd3040,
      22'd3168, 22'd3296, 22'd3424, 22'd3552, 22'd3680, 22'd3808, 22'd3936,
      22'd4064, 22'd4192, 22'd4320, 22'd4448, 22'd4704,
      22'd4960, 22'd5216, 22'd5472, 22'd5728, 22'd5984, 22'd6240, 22'd6240,
      22'd6496, 22'd6752, 22'd7008, 22'd7264, 22'd7520,
      22'd7776, 22'd8032, 22'd8288, 22'd8544, 22'd8800, 22'd9056, 22'd9312,
      22'd9568, 22'd9824, 22'd10080, 22'd10592,
      22'd11104, 22'd11616, 22'd12128, 22'd12640, 22'd13152, 22'd13664,
      22'd14176, 22'd14688, 22'd15200, 22'd15712,
      22'd16224, 22'd16736, 22'd17248, 22'd17760, 22'd18272, 22'd18784,
      22'd19296, 22'd19808, 22'd20320, 22'd21344,
      22'd22368, 22'd23392, 22'd24416, 22'd25440, 22'd26464, 22'd27488,
      22'd28512, 22'd29536, 22'd30560, 22'd31584,
      22'd32608, 22'd33632, 22'd34656, 22'd35680, 22'd36704, 22'd37728,
      22'd38752, 22'd39776, 22'd40800, 22'd41824,
      22'd43872, 22'd45920, 22'd47968, 22'd50016, 22'd52064, 22'd54112,
      22'd56160, 22'd56160, 22'd58208, 22'd60256,
      22'd62304, 22'd64352, 22'd66400, 22'd68448, 22'd70496, 22'd72544,
      22'd74592, 22'd76640, 22'd78688, 22'd80736,
      22'd82784, 22'd84832, 22'd86880, 22'd90976, 22'd95072, 22'd99168,
      22'd103264, 22'd107360, 22'd111456, 22'd115552,
      22'd119648, 22'd123744, 22'd127840, 22'd131936, 22'd136032, 22'd140128,
      22'd144224, 22'd148320, 22'd152416,
      22'd156512, 22'd160608, 22'd164704, 22'd168800, 22'd176992, 22'd185184,
      22'd193376, 22'd201568, 22'd209760,
      22'd217952, 22'd226144, 22'd234336, 22'd242528, 22'd250720, 22'd258912,
      22'd267104, 22'd275296, 22'd283488,
      22'd291680, 22'd299872, 22'd308064, 22'd316256, 22'd324448, 22'd332640,
      22'd340832, 22'd357212, 22'd373592,
      22'd389972, 22'd406352, 22'd422732, 22'd439112, 22'd455492, 22'd455492,
      22'd471872, 22'd488252,
      22'd504632, 22'd521012, 22'd537392, 22'd553772, 22'd570152, 22'd586532,
      22'd602912, 22'd619292,
      22'd635672, 22'd652052, 22'd668432, 22'd684812, 22'd701192, 22'd733952,
      22'd766712, 22'd799472,
      22'd832232, 22'd864992, 22'd897752, 22'd930512, 22'd963272, 22'd996032,
      22'd1028792, 22'd1061552,
      22'd1094312, 22'd1127072, 22'd1159832, 22'd1192592, 22'd1225352,
      22'd1258112, 22'd1290872, 22'd1323632,
      22'd1356392, 22'd1421912, 22'd1487432, 22'd1552952, 22'd1618472,
      22'd1683992, 22'd1749512, 22'd1815032,
      22'd1880552, 22'd1946072, 22'd2011592, 22'd2077112, 22'd2142632,
      22'd2208152, 22'd2273672, 22'd2339192,
      22'd2404712, 22'd2470232, 22'd2535752, 22'd2601272, 22'd2666792,
      22'd2732312, 22'd2863312, 22'd2994312,
      22'd3125312, 22'd3256312, 22'd3387312, 22'd3518312, 22'd3649312,
      22'd3780312
   };

endpackage
`default_nettype wire

### rtl/dahr_hit_calc.sv
// Combinational energy and time reconstruction for one channel transaction.
`default_nettype none
module dahr_hit_calc (
   input  wire logic [1:0]                              func,
   input  wire logic [1:0]                              hit_count,
   input  wire logic [dahr_pkg::AdcWidth-1:0]           adc_first,
   input  wire logic [dahr_pkg::TdcWidth-1:0]           tdc_first,
   input  wire logic [dahr_pkg::AdcWidth-1:0]           adc_second,
   input  wire logic [dahr_pkg::TdcWidth-1:0]           tdc_second,
   input  wire dahr_pkg::cfg_type                       cfg,
   output logic signed [dahr_pkg::EnergyWidth-1:0]      hit_energy,
   output logic signed [dahr_pkg::TimeWidth-1:0]        hit_time
);
   import dahr_pkg::*;

   logic [AdcWidth:0]                 idx1_lo;
   logic [AdcWidth:0]                 idx2_lo;
   logic [AdcWidth:0]                 idx1_hi;
   logic [AdcWidth:0]                 idx2_hi;
   logic [EdgeWidth:0]                edge_sum1;
   logic [EdgeWidth:0]                edge_sum2;
   logic [EdgeWidth-1:0]              mid1;
   logic [EdgeWidth-1:0]              mid2;
   logic signed [EnergyWidth-2:0]     e1;
   logic signed [EnergyWidth-2:0]     e2;
   logic signed [EnergyWidth-1:0]     e1_double;
   logic signed [EnergyWidth-1:0]     e2_double;
   logic signed [EnergyWidth-1:0]     e_sum;
   logic                              ok1;
   logic                              ok2;
   logic                              early1;
   logic                              below1;
   logic                              below2;
   logic signed [TimeWidth-1:0]       time1;
   logic signed [TimeWidth-1:0]       time2;
   logic signed [TimeWidth-1:0]       time_sum;
   func_type                          mode;

   assign idx1_lo   = {1'b0, adc_first};
   assign idx2_lo   = {1'b0, adc_second};
   assign idx1_hi   = {1'b0, adc_first} + 9'd1;
   assign idx2_hi   = {1'b0, adc_second} + 9'd1;
   assign edge_sum1 = {1'b0, BIN_EDGE[idx1_lo]} + {1'b0, BIN_EDGE[idx1_hi]};
   assign edge_sum2 = {1'b0, BIN_EDGE[idx2_lo]} + {1'b0, BIN_EDGE[idx2_hi]};
   assign mid1      = edge_sum1[EdgeWidth:1];
   assign mid2      = edge_sum2[EdgeWidth:1];

   assign e1 = $signed({1'b0, mid1}) - $signed({13'd0, cfg.pedestal_tenth_fc});
   assign e2 = $signed({1'b0, mid2}) - $signed({13'd0, cfg.pedestal_tenth_fc});
   assign e1_double = {e1, 1'b0};
   assign e2_double = {e2, 1'b0};
   assign e_sum     = {e1[EnergyWidth-2], e1} + {e2[EnergyWidth-2], e2};

   assign ok1    = tdc_first <= cfg.tdc_valid_max;
   assign ok2    = tdc_second <= cfg.tdc_valid_max;
   assign below1 = tdc_first < cfg.early_time_cut;
   assign below2 = tdc_second < cfg.early_time_cut;
   assign early1 = !ok1 || below1;

   assign time1 = ok1 ? $signed({6'd0, tdc_first, 1'b0}) : TIME_INVALID;
   assign time2 = ok2 ? $signed({6'd0, tdc_second, 1'b0}) : TIME_INVALID;
   assign time_sum = (ok1 && ok2)
      ? $signed({6'd0, {1'b0, tdc_first} + {1'b0, tdc_second}}) : TIME_INVALID;

   assign mode = func_type'(func);

   always_comb begin
      hit_energy = '0;
      hit_time   = '0;
      unique case (mode)
         FUNC_ANODE1: begin
            hit_energy = e1_double;
            hit_time   = time1;
         end
         FUNC_ANODE2: begin
            hit_energy = e2_double;
            hit_time   = time2;
         end
         FUNC_BOTH_FREE: begin
            if (hit_count == 2'd1) begin
               hit_energy = e1_double;
               hit_time   = time1;
            end else if (hit_count == 2'd2) begin
               hit_energy = e_sum;
               hit_time   = time_sum;
            end
         end
         FUNC_BOTH_CUT: begin
            if (hit_count == 2'd1) begin
               hit_energy = early1 ? '0 : e1_double;
               hit_time   = time1;
            end else if (hit_count == 2'd2) begin
               priority if (!(ok1 && ok2)) begin
                  hit_energy = e2_double;
                  hit_time   = TIME_INVALID;
               end else if (below1) begin
                  hit_energy = e2_double;
                  hit_time   = time2;
               end else if (below2) begin
                  hit_energy = e1_double;
                  hit_time   = time1;
               end else begin
                  hit_energy = e_sum;
                  hit_time   = time_sum;
               end
            end
         end
         default: begin
            hit_energy = '0;
            hit_time   = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/dual_anode_hit_reconstruction_core.sv
// Top level of the dual-anode hit reconstruction core.
//
// Usage:
//   Request channel (req_*): one transaction per channel with its mode, anode
//   count and the in-time ADC/TDC codes of both anodes.
//   Response channel (rsp_*): one hit per request with the channel id, the
//   energy in 0.025 GeV and the rise time in quarter-ns (-4000 = invalid TDC).
//   Register channel (csr_*): writes pedestal, early-time cut and largest
//   valid TDC code; always ready, write only while no transaction is in flight.
// A request passes through an input register, then the ROM lookup and mode
// selection into the response register, which drives rsp_valid.
// Throughput is one transaction per cycle while the receiver keeps rsp_ready high.
// Reset clears both valid flags and loads the register defaults (pedestal 90,
// cut 20, valid max 49).
// When the receiver stalls, the response register holds, the input register
// holds once full, and req_ready drops; no transaction is lost.
`default_nettype none
module dual_anode_hit_reconstruction_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [1:0]                             req_func,
   input  wire logic [dahr_pkg::ChannelWidth-1:0]      req_channel_id,
   input  wire logic [1:0]                             req_hit_count,
   input  wire logic [dahr_pkg::AdcWidth-1:0]          req_adc_first,
   input  wire logic [dahr_pkg::TdcWidth-1:0]          req_tdc_first,
   input  wire logic [dahr_pkg::AdcWidth-1:0]          req_adc_second,
   input  wire logic [dahr_pkg::TdcWidth-1:0]          req_tdc_second,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [dahr_pkg::ChannelWidth-1:0]           rsp_hit_channel,
   output logic signed [dahr_pkg::EnergyWidth-1:0]     rsp_hit_energy,
   output logic signed [dahr_pkg::TimeWidth-1:0]       rsp_hit_time,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [dahr_pkg::CsrIndexWidth-1:0]     csr_index,
   input  wire logic [dahr_pkg::CsrDataWidth-1:0]      csr_data
);
   import dahr_pkg::*;

   cfg_type                        cfg_ff;
   cfg_type                        cfg_in;

   logic                           s1_valid_ff;
   logic                           s1_valid_in;
   logic [1:0]                     s1_func_ff;
   logic [ChannelWidth-1:0]        s1_channel_ff;
   logic [1:0]                     s1_count_ff;
   logic [AdcWidth-1:0]            s1_adc1_ff;
   logic [TdcWidth-1:0]            s1_tdc1_ff;
   logic [AdcWidth-1:0]            s1_adc2_ff;
   logic [TdcWidth-1:0]            s1_tdc2_ff;

   logic                           out_valid_ff;
   logic                           out_valid_in;
   logic [ChannelWidth-1:0]        out_channel_ff;
   logic signed [EnergyWidth-1:0]  out_energy_ff;
   logic signed [TimeWidth-1:0]    out_time_ff;
   logic signed [EnergyWidth-1:0]  calc_energy;
   logic signed [TimeWidth-1:0]    calc_time;

   logic                           out_advance;
   logic                           s1_advance;
   logic                           req_take;
   csr_index_type                  csr_sel;

   assign out_advance = !out_valid_ff || rsp_ready;
   assign s1_advance  = s1_valid_ff && out_advance;
   assign req_ready   = !s1_valid_ff || out_advance;
   assign req_take    = req_valid && req_ready;
   assign csr_ready   = 1'b1;
   assign csr_sel     = csr_index_type'(csr_index);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_sel)
            CSR_PEDESTAL:  cfg_in.pedestal_tenth_fc = csr_data;
            CSR_EARLY_CUT: cfg_in.early_time_cut    = csr_data[TdcWidth-1:0];
            CSR_TDC_MAX:   cfg_in.tdc_valid_max     = csr_data[TdcWidth-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_advance);
   assign out_valid_in = s1_advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pedestal_tenth_fc <= PEDESTAL_RESET;
         cfg_ff.early_time_cut    <= EARLY_CUT_RESET;
         cfg_ff.tdc_valid_max     <= TDC_MAX_RESET;
         s1_valid_ff              <= 1'b0;
         out_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff    <= req_func;
         s1_channel_ff <= req_channel_id;
         s1_count_ff   <= req_hit_count;
         s1_adc1_ff    <= req_adc_first;
         s1_tdc1_ff    <= req_tdc_first;
         s1_adc2_ff    <= req_adc_second;
         s1_tdc2_ff    <= req_tdc_second;
      end
      if (s1_advance) begin
         out_channel_ff <= s1_channel_ff;
         out_energy_ff  <= calc_energy;
         out_time_ff    <= calc_time;
      end
   end

   dahr_hit_calc u_calc (
      .func       (s1_func_ff),
      .hit_count  (s1_count_ff),
      .adc_first  (s1_adc1_ff),
      .tdc_first  (s1_tdc1_ff),
      .adc_second (s1_adc2_ff),
      .tdc_second (s1_tdc2_ff),
      .cfg        (cfg_ff),
      .hit_energy (calc_energy),
      .hit_time   (calc_time)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_hit_channel = out_channel_ff;
   assign rsp_hit_energy  = out_energy_ff;
   assign rsp_hit_time    = out_time_ff;

endmodule
`default_nettype wire

### bench/hit_prediction_checker.sv
// Watches the request, response and register channels and predicts and checks every hit.
module hit_prediction_checker (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   input  logic                                      req_ready,
   input  logic [1:0]                                req_func,
   input  logic [dahr_pkg::ChannelWidth-1:0]         req_channel_id,
   input  logic [1:0]                                req_hit_count,
   input  logic [dahr_pkg::AdcWidth-1:0]             req_adc_first,
   input  logic [dahr_pkg::TdcWidth-1:0]             req_tdc_first,
   input  logic [dahr_pkg::AdcWidth-1:0]             req_adc_second,
   input  logic [dahr_pkg::TdcWidth-1:0]             req_tdc_second,
   input  logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   input  logic [dahr_pkg::ChannelWidth-1:0]         rsp_hit_channel,
   input  logic signed [dahr_pkg::EnergyWidth-1:0]   rsp_hit_energy,
   input  logic signed [dahr_pkg::TimeWidth-1:0]     rsp_hit_time,
   input  logic                                      csr_valid,
   input  logic                                      csr_ready,
   input  logic [dahr_pkg::CsrIndexWidth-1:0]        csr_index,
   input  logic [dahr_pkg::CsrDataWidth-1:0]         csr_data,
   output int                                        mismatch_count,
   output int                                        hits_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import dahr_pkg::*;

   typedef struct packed {
      logic [ChannelWidth-1:0]       channel;
      logic signed [EnergyWidth-1:0] energy;
      logic signed [TimeWidth-1:0]   rise;
   } hit_type;

   cfg_type settings;
   hit_type expected_hits[$];

   initial begin
      mismatch_count = 0;
      hits_pending = 0;
   end

   function automatic int anode_energy(input logic [AdcWidth-1:0] adc,
                                       input logic [PedWidth-1:0] pedestal);
      int k;
      k = adc;
      return ((int'(BIN_EDGE[k]) + int'(BIN_EDGE[k + 1])) >>> 1) - int'(pedestal);
   endfunction

   function automatic hit_type reconstruct_hit(input cfg_type c, input func_type mode,
                                               input logic [1:0] count,
                                               input logic [ChannelWidth-1:0] channel,
                                               input logic [AdcWidth-1:0] adc1,
                                               input logic [TdcWidth-1:0] tdc1,
                                               input logic [AdcWidth-1:0] adc2,
                                               input logic [TdcWidth-1:0] tdc2);
      hit_type h;
      int e1, e2, rise1, rise2, pair_rise, energy, rise;
      bit ok1, ok2, early1, early2;
      e1 = anode_energy(adc1, c.pedestal_tenth_fc);
      e2 = anode_energy(adc2, c.pedestal_tenth_fc);
      ok1 = tdc1 <= c.tdc_valid_max;
      ok2 = tdc2 <= c.tdc_valid_max;
      rise1 = ok1 ? 2 * int'(tdc1) : int'(TIME_INVALID);
      rise2 = ok2 ? 2 * int'(tdc2) : int'(TIME_INVALID);
      early1 = !ok1 || tdc1 < c.early_time_cut;
      early2 = tdc2 < c.early_time_cut;
      pair_rise = (ok1 && ok2) ? int'(tdc1) + int'(tdc2) : int'(TIME_INVALID);
      energy = 0;
      rise = 0;
      case (mode)
         FUNC_ANODE1: begin
            energy = 2 * e1;
            rise = rise1;
         end
         FUNC_ANODE2: begin
            energy = 2 * e2;
            rise = rise2;
         end
         default: begin
            if (count == 2'd1) begin
               rise = rise1;
               energy = (mode == FUNC_BOTH_CUT && early1) ? 0 : 2 * e1;
            end else if (count == 2'd2) begin
               if (mode == FUNC_BOTH_FREE) begin
                  energy = e1 + e2;
                  rise = pair_rise;
               end else if (!(ok1 && ok2)) begin
                  energy = 2 * e2;
                  rise = int'(TIME_INVALID);
               end else if (early1) begin
                  energy = 2 * e2;
                  rise = rise2;
               end else if (early2) begin
                  energy = 2 * e1;
                  rise = rise1;
               end else begin
                  energy = e1 + e2;
                  rise = pair_rise;
               end
            end
         end
      endcase
      h.channel = channel;
      h.energy = energy[EnergyWidth-1:0];
      h.rise = rise[TimeWidth-1:0];
      return h;
   endfunction

   always @(posedge clock) begin
      hit_type want;
      if (reset) begin
         settings.pedestal_tenth_fc = PEDESTAL_RESET;
         settings.early_time_cut = EARLY_CUT_RESET;
         settings.tdc_valid_max = TDC_MAX_RESET;
         expected_hits.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_PEDESTAL:  settings.pedestal_tenth_fc = csr_data[PedWidth-1:0];
               CSR_EARLY_CUT: settings.early_time_cut = csr_data[TdcWidth-1:0];
               CSR_TDC_MAX:   settings.tdc_valid_max = csr_data[TdcWidth-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_hits.insert(expected_hits.size(),
               reconstruct_hit(settings, func_type'(req_func),
               req_hit_count, req_channel_id, req_adc_first, req_tdc_first,
               req_adc_second, req_tdc_second));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_hits.size() == 0) begin
               $error("hit with no request pending: channel %h", rsp_hit_channel);
               mismatch_count++;
            end else begin
               want = expected_hits.pop_front();
               if (rsp_hit_channel !== want.channel) begin
                  $error("hit_channel: expected %h, actual %h", want.channel, rsp_hit_channel);
                  mismatch_count++;
               end
               if (rsp_hit_energy !== want.energy) begin
                  $error("hit_energy: expected %0d, actual %0d", want.energy, rsp_hit_energy);
                  mismatch_count++;
               end
               if (rsp_hit_time !== want.rise) begin
                  $error("hit_time: expected %0d, actual %0d", want.rise, rsp_hit_time);
                  mismatch_count++;
               end
            end
         end
      end
      hits_pending = expected_hits.size();
   end

endmodule

### bench/tb_top.sv
// Stimulus, clock, reset and verdict for the dual-anode hit reconstruction core.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import dahr_pkg::*;

   localparam logic [CsrIndexWidth-1:0] CSR_UNMAPPED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 250;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_func = '0;
   logic [ChannelWidth-1:0] req_channel_id = '0;
   logic [1:0] req_hit_count = '0;
   logic [AdcWidth-1:0] req_adc_first = '0;
   logic [TdcWidth-1:0] req_tdc_first = '0;
   logic [AdcWidth-1:0] req_adc_second = '0;
   logic [TdcWidth-1:0] req_tdc_second = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [ChannelWidth-1:0] rsp_hit_channel;
   logic signed [EnergyWidth-1:0] rsp_hit_energy;
   logic signed [TimeWidth-1:0] rsp_hit_time;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_data = '0;

   int mismatch_count;
   int hits_pending;
   int unsigned cycle_count = 0;
   bit steady = 1'b0;
   bit hold_off_request = 1'b0;
   logic [TdcWidth-1:0] cut_now = EARLY_CUT_RESET;
   logic [TdcWidth-1:0] tdc_max_now = TDC_MAX_RESET;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   dual_anode_hit_reconstruction_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_channel_id(req_channel_id), .req_hit_count(req_hit_count),
      .req_adc_first(req_adc_first), .req_tdc_first(req_tdc_first),
      .req_adc_second(req_adc_second), .req_tdc_second(req_tdc_second),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit_channel(rsp_hit_channel),
      .rsp_hit_energy(rsp_hit_energy), .rsp_hit_time(rsp_hit_time),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   hit_prediction_checker hit_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_channel_id(req_channel_id), .req_hit_count(req_hit_count),
      .req_adc_first(req_adc_first), .req_tdc_first(req_tdc_first),
      .req_adc_second(req_adc_second), .req_tdc_second(req_tdc_second),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit_channel(rsp_hit_channel),
      .rsp_hit_energy(rsp_hit_energy), .rsp_hit_time(rsp_hit_time),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .mismatch_count(mismatch_count), .hits_pending(hits_pending)
   );

   // hold off once for a long stretch, otherwise stall at random unless steady is set
   always @(posedge clock) begin
      if (hold_off_request) begin
         hold_off_request = 1'b0;
         rsp_ready <= 1'b0;
         repeat (300) @(posedge clock);
      end else begin
         rsp_ready <= steady || ($urandom_range(99, 0) >= 33);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic send_hit(input func_type mode, input logic [1:0] count,
                           input logic [ChannelWidth-1:0] channel,
                           input logic [AdcWidth-1:0] adc1, input logic [TdcWidth-1:0] tdc1,
                           input logic [AdcWidth-1:0] adc2, input logic [TdcWidth-1:0] tdc2);
      if (!steady) begin
         while ($urandom_range(99, 0) < 33) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_func <= mode;
      req_hit_count <= count;
      req_channel_id <= channel;
      req_adc_first <= adc1;
      req_tdc_first <= tdc1;
      req_adc_second <= adc2;
      req_tdc_second <= tdc2;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic logic [TdcWidth-1:0] pick_tdc();
      case ($urandom_range(3, 0))
         0: return cut_now - 6'd1 + 6'($urandom_range(2, 0));
         1: return tdc_max_now + 6'($urandom_range(1, 0));
         default: return 6'($urandom_range(63, 0));
      endcase
   endfunction

   task automatic send_random_hit();
      int r;
      logic [1:0] count;
      r = $urandom_range(9, 0);
      count = (r < 4) ? 2'd2 : (r < 7) ? 2'd1 : (r == 7) ? 2'd0 : 2'd3;
      send_hit(func_type'($urandom_range(3, 0)), count, $urandom(),
               8'($urandom_range(255, 0)), pick_tdc(), 8'($urandom_range(255, 0)), pick_tdc());
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (hits_pending != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] index,
                            input logic [CsrDataWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic configure(input logic [CsrDataWidth-1:0] pedestal,
                            input logic [CsrDataWidth-1:0] cut,
                            input logic [CsrDataWidth-1:0] tdc_max, input bit poke_unmapped);
      if (poke_unmapped) write_csr(CSR_UNMAPPED, 10'($urandom_range(1023, 0)));
      write_csr(CSR_PEDESTAL, pedestal);
      write_csr(CSR_EARLY_CUT, cut);
      write_csr(CSR_TDC_MAX, tdc_max);
      csr_valid <= 1'b0;
      cut_now = cut[TdcWidth-1:0];
      tdc_max_now = tdc_max[TdcWidth-1:0];
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_hit(FUNC_ANODE1, 2'd1, 32'h0000_0000, 8'd0, 6'd0, 8'd255, 6'd63);
      send_hit(FUNC_ANODE1, 2'd0, 32'hFFFF_FFFF, 8'd255, 6'd63, 8'd0, 6'd0);
      send_hit(FUNC_ANODE2, 2'd2, 32'h5555_AAAA, 8'd0, 6'd0, 8'd255, 6'd49);
      send_hit(FUNC_ANODE2, 2'd3, 32'hAAAA_5555, 8'd255, 6'd10, 8'd0, 6'd50);
      send_hit(FUNC_ANODE1, 2'd2, $urandom(), 8'd1, 6'd49, 8'd2, 6'd50);
      send_hit(FUNC_BOTH_FREE, 2'd1, $urandom(), 8'd200, 6'd30, 8'd100, 6'd60);
      send_hit(FUNC_BOTH_FREE, 2'd2, $urandom(), 8'd255, 6'd49, 8'd255, 6'd49);
      send_hit(FUNC_BOTH_FREE, 2'd2, $urandom(), 8'd80, 6'd50, 8'd90, 6'd3);
      send_hit(FUNC_BOTH_FREE, 2'd2, $urandom(), 8'd80, 6'd3, 8'd90, 6'd63);
      send_hit(FUNC_BOTH_FREE, 2'd0, $urandom(), 8'd120, 6'd25, 8'd130, 6'd25);
      send_hit(FUNC_BOTH_FREE, 2'd3, $urandom(), 8'd120, 6'd25, 8'd130, 6'd25);
      send_hit(FUNC_BOTH_CUT, 2'd1, $urandom(), 8'd150, 6'd19, 8'd7, 6'd40);
      send_hit(FUNC_BOTH_CUT, 2'd1, $urandom(), 8'd150, 6'd20, 8'd7, 6'd40);
      send_hit(FUNC_BOTH_CUT, 2'd1, $urandom(), 8'd150, 6'd63, 8'd7, 6'd40);
      send_hit(FUNC_BOTH_CUT, 2'd2, $urandom(), 8'd60, 6'd50, 8'd70, 6'd30);
      send_hit(FUNC_BOTH_CUT, 2'd2, $urandom(), 8'd60, 6'd30, 8'd70, 6'd63);
      send_hit(FUNC_BOTH_CUT, 2'd2, $urandom(), 8'd60, 6'd10, 8'd70, 6'd5);
      send_hit(FUNC_BOTH_CUT, 2'd2, $urandom(), 8'd60, 6'd19, 8'd70, 6'd35);
      send_hit(FUNC_BOTH_CUT, 2'd2, $urandom(), 8'd60, 6'd35, 8'd70, 6'd19);
      send_hit(FUNC_BOTH_CUT, 2'd2, $urandom(), 8'd255, 6'd20, 8'd254, 6'd49);
      send_hit(FUNC_BOTH_CUT, 2'd0, $urandom(), 8'd60, 6'd30, 8'd70, 6'd30);
      send_hit(FUNC_BOTH_CUT, 2'd3, $urandom(), 8'd60, 6'd30, 8'd70, 6'd30);

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         case (phase)
            0: configure(10'd0, 10'd0, 10'd63, 1'b0);
            1: configure(10'd1023, 10'd63, 10'd0, 1'b1);
            2: configure(10'd90, 10'd20, 10'd49, 1'b0);
            default: configure(10'($urandom_range(1023, 0)), 10'($urandom_range(1023, 0)),
                               10'($urandom_range(1023, 0)), phase == 4);
         endcase
         steady = (phase == 0);
         if (phase == 2) hold_off_request = 1'b1;
         repeat (PHASE_ITEMS) send_random_hit();
      end
      steady = 1'b0;
      drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && hits_pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/dahr_pkg.sv
rtl/dahr_hit_calc.sv
rtl/dual_anode_hit_reconstruction_core.sv
bench/hit_prediction_checker.sv
bench/tb_top.sv
